### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the inverse block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must never hold outside reset
`define M4_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: forbidden condition");

// antecedent implies consequent in the same cycle
`define M4_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication broken");

`endif

### rtl/m4inv_pkg.sv
// ----------------------------------------------------------------------------
// m4inv_pkg
// types, widths and permutation table for the 4x4 fixed-point inverse
// ----------------------------------------------------------------------------
package m4inv_pkg;

   localparam int ELEM_WIDTH    = 32;
   localparam int FRAC_BITS     = 16;
   localparam int LIMB_WIDTH    = 32;
   localparam int NUM_LIMBS     = 4;
   localparam int WIDE_WIDTH    = 136;
   localparam int PROD_WIDTH    = LIMB_WIDTH + ELEM_WIDTH + 1;
   localparam int QUO_WIDTH     = ELEM_WIDTH + 1;
   localparam int DIV_STEPS     = WIDE_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS + 1);

   localparam logic [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
   localparam logic [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [ELEM_WIDTH-1:0] element_0;
      logic signed [ELEM_WIDTH-1:0] element_1;
      logic signed [ELEM_WIDTH-1:0] element_2;
      logic signed [ELEM_WIDTH-1:0] element_3;
   } m4inv_req_type;

   typedef struct packed {
      logic signed [ELEM_WIDTH-1:0] inv_0;
      logic signed [ELEM_WIDTH-1:0] inv_1;
      logic signed [ELEM_WIDTH-1:0] inv_2;
      logic signed [ELEM_WIDTH-1:0] inv_3;
      logic                         singular;
      logic                         saturated;
      logic                         last_row;
   } m4inv_rsp_type;

   typedef struct packed {
      logic                  start;
      logic [WIDE_WIDTH-1:0] num;
      logic [WIDE_WIDTH-1:0] den;
   } m4inv_div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [QUO_WIDTH-1:0] quo;
      logic                 ovf;
   } m4inv_div_res_type;

   // column picked by factor f of 3x3 permutation k
   function automatic logic [1:0] perm_col(input logic [2:0] k, input logic [1:0] f);
      logic [1:0] c;
      c = 2'd0;
      case (k)
         3'd0: c = f;
         3'd1: c = (f == 2'd0) ? 2'd1 : ((f == 2'd1) ? 2'd2 : 2'd0);
         3'd2: c = (f == 2'd0) ? 2'd2 : ((f == 2'd1) ? 2'd0 : 2'd1);
         3'd3: c = (f == 2'd0) ? 2'd0 : ((f == 2'd1) ? 2'd2 : 2'd1);
         3'd4: c = (f == 2'd0) ? 2'd2 : ((f == 2'd1) ? 2'd1 : 2'd0);
         3'd5: c = (f == 2'd0) ? 2'd1 : ((f == 2'd1) ? 2'd0 : 2'd2);
         default: c = 2'd0;
      endcase
      return c;
   endfunction

   // odd permutations
   function automatic logic perm_neg(input logic [2:0] k);
      return (k == 3'd3) || (k == 3'd4) || (k == 3'd5);
   endfunction

endpackage

### rtl/matrix4_inverse_cramer.sv
// order: input rows are stored as they arrive; after row 3 the determinant is
// formed, then the inverse rows are computed and sent one after another
// a new matrix is accepted only after the last inverse row; speed is set by the
// shared 33x32 multiplier (cofactor products) and one-bit-per-cycle divider
// singular matrix: four zero rows follow the determinant at once
// reset: synchronous, clears the sequencer, row count and output valid
// ----------------------------------------------------------------------------
// matrix4_inverse_cramer
// 4x4 Q16.16 inverse by adjugate and determinant, shared multiplier sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix4_inverse_cramer
   import m4inv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  m4inv_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output m4inv_rsp_type rsp_data
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_LD0  = 8'b0000_0010,
      ST_LDE  = 8'b0000_0100,
      ST_MUL  = 8'b0000_1000,
      ST_ADD  = 8'b0001_0000,
      ST_COF  = 8'b0010_0000,
      ST_DIV  = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] row_cnt_ff, row_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic [ELEM_WIDTH-1:0]        elem_ff [16];
   logic [ELEM_WIDTH-1:0]        elem_in [16];
   logic                         phase_ff, phase_in;   // 0: determinant, 1: output rows
   logic [1:0]                   r_ff, r_in;
   logic [2:0]                   k_ff, k_in;
   logic [1:0]                   f_ff, f_in;           // 3 selects the first-column factor
   logic [1:0]                   limb_ff, limb_in;
   logic [1:0]                   col_ff, col_in;
   logic signed [WIDE_WIDTH-1:0] t_ff, t_in;
   logic signed [WIDE_WIDTH-1:0] p_ff, p_in;
   logic signed [WIDE_WIDTH-1:0] acc_ff, acc_in;
   logic signed [WIDE_WIDTH-1:0] det_ff, det_in;
   logic signed [ELEM_WIDTH-1:0] ereg_ff, ereg_in;
   logic                         singular_ff, singular_in;
   logic                         sat_ff, sat_in;
   logic                         neg_ff, neg_in;
   logic [ELEM_WIDTH-1:0]        inv_ff [4];
   logic [ELEM_WIDTH-1:0]        inv_in [4];
   m4inv_rsp_type                rsp_ff, rsp_in;

   logic [1:0]                   c_sel, pc, rd_row, rd_col;
   logic signed [ELEM_WIDTH-1:0] e_rd;
   logic [LIMB_WIDTH-1:0]        limb;
   logic signed [LIMB_WIDTH:0]   mul_a;
   logic signed [PROD_WIDTH-1:0] prod;
   logic signed [WIDE_WIDTH-1:0] prod_ext, term, p_sum, det_sum, cof;
   logic [QUO_WIDTH-1:0]         q;
   logic                         neg_eff, sat_now;
   logic [ELEM_WIDTH-1:0]        val;
   m4inv_div_cmd_type            div_cmd;
   m4inv_div_res_type            div_res;

   // operand address for the current factor of the current permutation
   always_comb begin
      c_sel = phase_ff ? col_ff : 2'd0;
      pc    = perm_col(k_ff, f_ff);
      if (f_ff == 2'd3) begin
         rd_row = r_ff;
         rd_col = 2'd0;
      end else begin
         rd_row = (f_ff >= r_ff) ? (f_ff + 2'd1) : f_ff;
         rd_col = (pc >= c_sel) ? (pc + 2'd1) : pc;
      end
      e_rd = elem_ff[{rd_row, rd_col}];
   end

   always_comb begin
      case (limb_ff)
         2'd0:    limb = t_ff[31:0];
         2'd1:    limb = t_ff[63:32];
         2'd2:    limb = t_ff[95:64];
         default: limb = t_ff[127:96];
      endcase
      // only the top limb carries the sign
      mul_a    = (limb_ff == 2'd3) ? {limb[LIMB_WIDTH-1], limb} : {1'b0, limb};
      prod_ext = {{(WIDE_WIDTH-PROD_WIDTH){prod[PROD_WIDTH-1]}}, prod};
      term     = prod_ext <<< {limb_ff, 5'd0};
      p_sum    = p_ff + term;
      det_sum  = det_ff + p_sum;
      cof      = (r_ff[0] ^ c_sel[0]) ? -acc_ff : acc_ff;
   end

   m4inv_mul u_mul (
      .clock      (clock),
      .op_a       (mul_a),
      .op_b       (ereg_ff),
      .product_ff (prod)
   );

   always_comb begin
      div_cmd.start = (state_ff == ST_COF) && phase_ff;
      div_cmd.num   = (cof[WIDE_WIDTH-1] ? -cof : cof) <<< (2 * FRAC_BITS);
      div_cmd.den   = det_ff[WIDE_WIDTH-1] ? -det_ff : det_ff;
   end

   m4inv_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // rounding toward zero and clipping of the quotient
   always_comb begin
      q       = div_res.quo;
      neg_eff = neg_ff && ((q != '0) || div_res.ovf);
      sat_now = div_res.ovf | q[QUO_WIDTH-1] |
                (neg_eff ? (q[ELEM_WIDTH-1] & (|q[ELEM_WIDTH-2:0])) : q[ELEM_WIDTH-1]);
      if (sat_now) begin
         val = neg_eff ? ELEM_MIN : ELEM_MAX;
      end else begin
         val = neg_eff ? (-q[ELEM_WIDTH-1:0]) : q[ELEM_WIDTH-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_cnt_in   = row_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      elem_in      = elem_ff;
      phase_in     = phase_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      f_in         = f_ff;
      limb_in      = limb_ff;
      col_in       = col_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      det_in       = det_ff;
      ereg_in      = ereg_ff;
      singular_in  = singular_ff;
      sat_in       = sat_ff;
      neg_in       = neg_ff;
      inv_in       = inv_ff;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               elem_in[{row_cnt_ff, 2'd0}] = req_data.element_0;
               elem_in[{row_cnt_ff, 2'd1}] = req_data.element_1;
               elem_in[{row_cnt_ff, 2'd2}] = req_data.element_2;
               elem_in[{row_cnt_ff, 2'd3}] = req_data.element_3;
               row_cnt_in = row_cnt_ff + 2'd1;
               if (row_cnt_ff == 2'd3) begin
                  phase_in    = 1'b0;
                  r_in        = 2'd0;
                  k_in        = 3'd0;
                  f_in        = 2'd0;
                  col_in      = 2'd0;
                  acc_in      = '0;
                  det_in      = '0;
                  singular_in = 1'b0;
                  state_in    = ST_LD0;
               end
            end
         end
         ST_LD0: begin
            t_in     = {{(WIDE_WIDTH-ELEM_WIDTH){e_rd[ELEM_WIDTH-1]}}, e_rd};
            f_in     = 2'd1;
            state_in = ST_LDE;
         end
         ST_LDE: begin
            ereg_in  = e_rd;
            p_in     = '0;
            limb_in  = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            p_in = p_sum;
            if (limb_ff != 2'd3) begin
               limb_in  = limb_ff + 2'd1;
               state_in = ST_MUL;
            end else if (f_ff == 2'd3) begin
               // determinant term finished
               det_in = det_sum;
               if (r_ff == 2'd3) begin
                  if (det_sum == '0) begin
                     singular_in           = 1'b1;
                     rsp_in                = '0;
                     rsp_in.singular       = 1'b1;
                     rsp_valid_in          = 1'b1;
                     col_in                = 2'd0;
                     state_in              = ST_OUT;
                  end else begin
                     phase_in = 1'b1;
                     col_in   = 2'd0;
                     r_in     = 2'd0;
                     k_in     = 3'd0;
                     f_in     = 2'd0;
                     acc_in   = '0;
                     sat_in   = 1'b0;
                     state_in = ST_LD0;
                  end
               end else begin
                  r_in     = r_ff + 2'd1;
                  k_in     = 3'd0;
                  f_in     = 2'd0;
                  acc_in   = '0;
                  state_in = ST_LD0;
               end
            end else if (f_ff != 2'd2) begin
               t_in     = p_sum;
               f_in     = f_ff + 2'd1;
               state_in = ST_LDE;
            end else begin
               acc_in = perm_neg(k_ff) ? (acc_ff - p_sum) : (acc_ff + p_sum);
               f_in   = 2'd0;
               if (k_ff != 3'd5) begin
                  k_in     = k_ff + 3'd1;
                  state_in = ST_LD0;
               end else begin
                  state_in = ST_COF;
               end
            end
         end
         ST_COF: begin
            if (phase_ff) begin
               neg_in   = cof[WIDE_WIDTH-1] ^ det_ff[WIDE_WIDTH-1];
               state_in = ST_DIV;
            end else begin
               t_in     = cof;
               f_in     = 2'd3;
               state_in = ST_LDE;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               inv_in[r_ff] = val;
               sat_in       = sat_ff | sat_now;
               if (r_ff == 2'd3) begin
                  rsp_in.inv_0     = inv_in[0];
                  rsp_in.inv_1     = inv_in[1];
                  rsp_in.inv_2     = inv_in[2];
                  rsp_in.inv_3     = inv_in[3];
                  rsp_in.singular  = 1'b0;
                  rsp_in.saturated = sat_ff | sat_now;
                  rsp_in.last_row  = (col_ff == 2'd3);
                  rsp_valid_in     = 1'b1;
                  state_in         = ST_OUT;
               end else begin
                  r_in     = r_ff + 2'd1;
                  k_in     = 3'd0;
                  f_in     = 2'd0;
                  acc_in   = '0;
                  state_in = ST_LD0;
               end
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (col_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in = col_ff + 2'd1;
                  if (singular_ff) begin
                     rsp_in.last_row = (col_ff == 2'd2);
                     rsp_valid_in    = 1'b1;
                  end else begin
                     r_in     = 2'd0;
                     k_in     = 3'd0;
                     f_in     = 2'd0;
                     acc_in   = '0;
                     sat_in   = 1'b0;
                     state_in = ST_LD0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_cnt_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff     <= elem_in;
      phase_ff    <= phase_in;
      r_ff        <= r_in;
      k_ff        <= k_in;
      f_ff        <= f_in;
      limb_ff     <= limb_in;
      col_ff      <= col_in;
      t_ff        <= t_in;
      p_ff        <= p_in;
      acc_ff      <= acc_in;
      det_ff      <= det_in;
      ereg_ff     <= ereg_in;
      singular_ff <= singular_in;
      sat_ff      <= sat_in;
      neg_ff      <= neg_in;
      inv_ff      <= inv_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `M4_ASSERT_NEVER(a_no_overlap, clock, reset, req_ready && rsp_valid)
   `M4_ASSERT_IMP(a_sing_zero, clock, reset, rsp_valid && rsp_data.singular, (rsp_data.inv_0 == '0) && (rsp_data.inv_3 == '0) && !rsp_data.saturated)
   `M4_ASSERT_IMP(a_div_wait, clock, reset, div_res.done, state_ff == ST_DIV)
   `M4_ASSERT_IMP(a_out_valid, clock, reset, state_ff == ST_OUT, rsp_valid)

endmodule

### rtl/m4inv_mul.sv
// ----------------------------------------------------------------------------
// m4inv_mul
// shared signed 33x32 multiplier with registered product
// ----------------------------------------------------------------------------
module m4inv_mul
   import m4inv_pkg::*;
(
   input  logic                         clock,
   input  logic signed [LIMB_WIDTH:0]   op_a,
   input  logic signed [ELEM_WIDTH-1:0] op_b,
   output logic signed [PROD_WIDTH-1:0] product_ff
);

   logic signed [PROD_WIDTH-1:0] product_in;

   // operands widened first so the full product is kept
   assign product_in = PROD_WIDTH'(op_a) * PROD_WIDTH'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

### rtl/m4inv_div.sv
// ----------------------------------------------------------------------------
// m4inv_div
// restoring magnitude divider, one quotient bit per cycle, overflow sticky
// ----------------------------------------------------------------------------
module m4inv_div
   import m4inv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  m4inv_div_cmd_type cmd,
   output m4inv_div_res_type res
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [WIDE_WIDTH:0]      rem_ff, rem_in;
   logic [WIDE_WIDTH-1:0]    num_ff, num_in;
   logic [WIDE_WIDTH-1:0]    den_ff, den_in;
   logic [QUO_WIDTH-1:0]     quo_ff, quo_in;
   logic                     ovf_ff, ovf_in;
   logic [WIDE_WIDTH:0]      rem_sh;
   logic                     fits;

   always_comb begin
      rem_sh  = {rem_ff[WIDE_WIDTH-1:0], num_ff[WIDE_WIDTH-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         num_in  = cmd.num;
         den_in  = cmd.den;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         num_in = {num_ff[WIDE_WIDTH-2:0], 1'b0};
         // a bit leaving the top means the quotient cannot fit
         ovf_in = ovf_ff | quo_ff[QUO_WIDTH-1];
         quo_in = {quo_ff[QUO_WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign res.done = done_ff;
   assign res.quo  = quo_ff;
   assign res.ovf  = ovf_ff;

endmodule
